// ----- rtl/core/lsrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_pkg
// shared constants and register codes for the segment clipping core
// ----------------------------------------------------------------------------
package lsrc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_t;

endpackage

// ----- rtl/core/lsrc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrc_div
// four-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lsrc_div #(
  parameter int COORD_WIDTH = lsrc_pkg::COORD_WIDTH_DEF,
  parameter int SIDE_W      = 4 * lsrc_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [3:0][2*COORD_WIDTH+1:0]          in_num,
  input  logic [3:0][COORD_WIDTH:0]              in_den,
  input  logic [SIDE_W-1:0]                      in_side,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [3:0][COORD_WIDTH-1:0]            out_quo,
  output logic [SIDE_W-1:0]                      out_side
);

  localparam int W    = COORD_WIDTH;
  localparam int NWID = 2 * W + 2;
  localparam int DNW  = W + 1;

  logic             v_r    [W];
  logic             rdy    [W+1];
  logic [NWID-1:0]  rem_r  [W][4];
  logic [DNW-1:0]   den_r  [W][4];
  logic [W-1:0]     quo_r  [W][4];
  logic [SIDE_W-1:0] side_r [W];

  assign rdy[W]   = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = v_r[W-1];
  assign out_side  = side_r[W-1];

  for (genvar j = 0; j < W; j++) begin : g_stage
    localparam int B = W - 1 - j;
    logic pv;

    assign rdy[j] = !v_r[j] || rdy[j+1];

    if (j == 0) begin : g_first
      assign pv = in_valid;
    end else begin : g_next
      assign pv = v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= pv;
      end
    end

    if (j == 0) begin : g_side0
      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          side_r[j] <= in_side;
        end
      end
    end else begin : g_siden
      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          side_r[j] <= side_r[j-1];
        end
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [NWID-1:0] prem;
      logic [NWID-1:0] nrem;
      logic [NWID-1:0] dext;
      logic [DNW-1:0]  pden;
      logic [W-1:0]    pquo;
      logic [W-1:0]    nquo;
      logic            ge;

      if (j == 0) begin : g_src0
        assign prem = in_num[l];
        assign pden = in_den[l];
        assign pquo = '0;
      end else begin : g_srcn
        assign prem = rem_r[j-1][l];
        assign pden = den_r[j-1][l];
        assign pquo = quo_r[j-1][l];
      end

      assign dext = NWID'(pden);
      assign ge   = (prem >> B) >= dext;

      always_comb begin
        nrem    = ge ? (prem - (dext << B)) : prem;
        nquo    = pquo;
        nquo[B] = ge;
      end

      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          rem_r[j][l] <= nrem;
          den_r[j][l] <= pden;
          quo_r[j][l] <= nquo;
        end
      end

      assign out_quo[l] = quo_r[W-1][l];
    end
  end

endmodule

// ----- rtl/core/line_segment_rect_clip_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_rect_clip_core
// segment against rectangle clipping with exact ratio bounds
// throughput: one word per cycle unless stalled, via fully pipelined ratio
// compares and the COORD_WIDTH-stage divider; stalls back up stage by stage
// reset: synchronous active low, clears valid bits and loads default edges
// ----------------------------------------------------------------------------
module line_segment_rect_clip_core #(
  parameter int COORD_WIDTH = lsrc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic signed [COORD_WIDTH-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_start_x,
  input  logic signed [COORD_WIDTH-1:0]   in_start_y,
  input  logic signed [COORD_WIDTH-1:0]   in_end_x,
  input  logic signed [COORD_WIDTH-1:0]   in_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_visible,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_start_x,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_start_y,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_end_x,
  output logic signed [COORD_WIDTH-1:0]   out_clipped_end_y
);

  localparam int W      = COORD_WIDTH;
  localparam int DW     = W + 1;
  localparam int PW     = 2 * DW;
  localparam int NWID   = 2 * W + 2;
  localparam int SIDE_W = 4 * W + 1;
  localparam int NST    = 7;

  // configuration
  logic signed [W-1:0] clip_x_min_r, clip_x_max_r, clip_y_min_r, clip_y_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_x_min_r <= '0;
      clip_x_max_r <= {1'b0, {(W-1){1'b1}}};
      clip_y_min_r <= '0;
      clip_y_max_r <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_valid) begin
      case (lsrc_pkg::cfg_reg_t'(cfg_index))
        lsrc_pkg::REG_X_MIN: clip_x_min_r <= cfg_data;
        lsrc_pkg::REG_X_MAX: clip_x_max_r <= cfg_data;
        lsrc_pkg::REG_Y_MIN: clip_y_min_r <= cfg_data;
        lsrc_pkg::REG_Y_MAX: clip_y_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage control
  logic v_r [1:NST];
  logic rdy [1:NST+1];
  logic div_ready;

  assign rdy[NST+1] = div_ready;
  assign in_ready   = rdy[1];

  for (genvar k = 1; k <= NST; k++) begin : g_ctl
    assign rdy[k] = !v_r[k] || rdy[k+1];
    if (k == 1) begin : g_v1
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= in_valid;
        end
      end
    end else begin : g_vn
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: deltas, edge numerators, clamp to [0,1]
  logic signed [DW-1:0] c1 [2];
  logic signed [DW-1:0] c2 [2];
  logic signed [DW-1:0] lo [2];
  logic signed [DW-1:0] hi [2];

  assign c1[0] = DW'(in_start_x);
  assign c1[1] = DW'(in_start_y);
  assign c2[0] = DW'(in_end_x);
  assign c2[1] = DW'(in_end_y);
  assign lo[0] = DW'(clip_x_min_r);
  assign lo[1] = DW'(clip_y_min_r);
  assign hi[0] = DW'(clip_x_max_r);
  assign hi[1] = DW'(clip_y_max_r);

  logic                 s1_rej_r;
  logic signed [DW-1:0] s1_en_r   [2];
  logic signed [DW-1:0] s1_ed_r   [2];
  logic signed [DW-1:0] s1_xn_r   [2];
  logic signed [DW-1:0] s1_xd_r   [2];
  logic signed [W-1:0]  s1_base_r [2];
  logic [W-1:0]         s1_ad_r   [2];
  logic                 s1_neg_r  [2];
  logic                 rej_ax    [2];

  for (genvar a = 0; a < 2; a++) begin : g_axis
    logic signed [DW-1:0] dl, adl, nent, next;
    logic                 zero, pos;

    always_comb begin
      dl     = c2[a] - c1[a];
      zero   = (dl == '0);
      pos    = !dl[DW-1] && !zero;
      adl    = dl[DW-1] ? -dl : dl;
      nent   = pos ? (lo[a] - c1[a]) : (c1[a] - hi[a]);
      next   = pos ? (hi[a] - c1[a]) : (c1[a] - lo[a]);
      rej_ax[a] = zero && ((c1[a] < lo[a]) || (c1[a] > hi[a]));
    end

    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        if (zero || nent[DW-1]) begin
          s1_en_r[a] <= '0;
          s1_ed_r[a] <= DW'(1);
        end else begin
          s1_en_r[a] <= nent;
          s1_ed_r[a] <= adl;
        end
        if (zero || (next > adl)) begin
          s1_xn_r[a] <= DW'(1);
          s1_xd_r[a] <= DW'(1);
        end else begin
          s1_xn_r[a] <= next;
          s1_xd_r[a] <= adl;
        end
        s1_base_r[a] <= dl[DW-1] ? c2[a][W-1:0] : c1[a][W-1:0];
        s1_ad_r[a]   <= adl[W-1:0];
        s1_neg_r[a]  <= dl[DW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_rej_r <= rej_ax[0] || rej_ax[1];
    end
  end

  // stage 2: cross products between axes
  logic                 s2_rej_r;
  logic signed [PW-1:0] s2_pe_r [2];
  logic signed [PW-1:0] s2_pf_r [2];
  logic signed [DW-1:0] s2_en_r [2];
  logic signed [DW-1:0] s2_ed_r [2];
  logic signed [DW-1:0] s2_xn_r [2];
  logic signed [DW-1:0] s2_xd_r [2];
  logic signed [W-1:0]  s2_base_r [2];
  logic [W-1:0]         s2_ad_r [2];
  logic                 s2_neg_r [2];

  for (genvar a = 0; a < 2; a++) begin : g_s2
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        s2_pe_r[a]   <= s1_en_r[a] * s1_ed_r[1-a];
        s2_pf_r[a]   <= s1_xn_r[a] * s1_xd_r[1-a];
        s2_en_r[a]   <= s1_en_r[a];
        s2_ed_r[a]   <= s1_ed_r[a];
        s2_xn_r[a]   <= s1_xn_r[a];
        s2_xd_r[a]   <= s1_xd_r[a];
        s2_base_r[a] <= s1_base_r[a];
        s2_ad_r[a]   <= s1_ad_r[a];
        s2_neg_r[a]  <= s1_neg_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_rej_r <= s1_rej_r;
    end
  end

  // stage 3: pick entry max and exit min
  logic                 s3_rej_r;
  logic signed [DW-1:0] s3_u1n_r, s3_u1d_r, s3_u2n_r, s3_u2d_r;
  logic signed [W-1:0]  s3_base_r [2];
  logic [W-1:0]         s3_ad_r [2];
  logic                 s3_neg_r [2];
  logic                 pick_e0, pick_x0;

  assign pick_e0 = s2_pe_r[0] >= s2_pe_r[1];
  assign pick_x0 = s2_pf_r[0] <= s2_pf_r[1];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_rej_r  <= s2_rej_r;
      s3_u1n_r  <= pick_e0 ? s2_en_r[0] : s2_en_r[1];
      s3_u1d_r  <= pick_e0 ? s2_ed_r[0] : s2_ed_r[1];
      s3_u2n_r  <= pick_x0 ? s2_xn_r[0] : s2_xn_r[1];
      s3_u2d_r  <= pick_x0 ? s2_xd_r[0] : s2_xd_r[1];
      s3_base_r <= s2_base_r;
      s3_ad_r   <= s2_ad_r;
      s3_neg_r  <= s2_neg_r;
    end
  end

  // stage 4: entry against exit
  logic                 s4_rej_r;
  logic signed [PW-1:0] s4_a_r, s4_b_r;
  logic signed [DW-1:0] s4_u1n_r, s4_u1d_r, s4_u2n_r, s4_u2d_r;
  logic signed [W-1:0]  s4_base_r [2];
  logic [W-1:0]         s4_ad_r [2];
  logic                 s4_neg_r [2];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_rej_r  <= s3_rej_r;
      s4_a_r    <= s3_u1n_r * s3_u2d_r;
      s4_b_r    <= s3_u2n_r * s3_u1d_r;
      s4_u1n_r  <= s3_u1n_r;
      s4_u1d_r  <= s3_u1d_r;
      s4_u2n_r  <= s3_u2n_r;
      s4_u2d_r  <= s3_u2d_r;
      s4_base_r <= s3_base_r;
      s4_ad_r   <= s3_ad_r;
      s4_neg_r  <= s3_neg_r;
    end
  end

  // stage 5: visibility and per-lane multiplier operands
  // lanes: start x, start y, end x, end y
  logic                s5_vis_r;
  logic [W-1:0]        s5_m_r    [4];
  logic [W-1:0]        s5_ad_r   [4];
  logic [W-1:0]        s5_d_r    [4];
  logic signed [W-1:0] s5_base_r [4];

  for (genvar l = 0; l < 4; l++) begin : g_s5
    localparam int AX = l % 2;
    logic signed [DW-1:0] un, ud, mm;

    always_comb begin
      un = (l < 2) ? s4_u1n_r : s4_u2n_r;
      ud = (l < 2) ? s4_u1d_r : s4_u2d_r;
      mm = s4_neg_r[AX] ? (ud - un) : un;
    end

    always_ff @(posedge clk) begin
      if (rdy[5]) begin
        s5_m_r[l]    <= mm[W-1:0];
        s5_d_r[l]    <= ud[W-1:0];
        s5_ad_r[l]   <= s4_ad_r[AX];
        s5_base_r[l] <= s4_base_r[AX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_vis_r <= !s4_rej_r && (s4_a_r <= s4_b_r);
    end
  end

  // stage 6: scaled delta
  logic                s6_vis_r;
  logic [2*W-1:0]      s6_prod_r [4];
  logic [W-1:0]        s6_d_r    [4];
  logic signed [W-1:0] s6_base_r [4];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_vis_r  <= s5_vis_r;
      s6_d_r    <= s5_d_r;
      s6_base_r <= s5_base_r;
      for (int l = 0; l < 4; l++) begin
        s6_prod_r[l] <= s5_m_r[l] * s5_ad_r[l];
      end
    end
  end

  // stage 7: dividend and divisor for half-up rounding
  logic                  s7_vis_r;
  logic [3:0][NWID-1:0]  s7_num_r;
  logic [3:0][W:0]       s7_den_r;
  logic signed [W-1:0]   s7_base_r [4];

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_vis_r  <= s6_vis_r;
      s7_base_r <= s6_base_r;
      for (int l = 0; l < 4; l++) begin
        s7_num_r[l] <= {1'b0, s6_prod_r[l], 1'b0} + NWID'(s6_d_r[l]);
        s7_den_r[l] <= {s6_d_r[l], 1'b0};
      end
    end
  end

  // divider
  logic [SIDE_W-1:0]       div_side_in, div_side_out;
  logic                    div_valid;
  logic                    out_rdy;
  logic [3:0][W-1:0]       div_quo;

  assign div_side_in = {s7_vis_r, s7_base_r[0], s7_base_r[1], s7_base_r[2], s7_base_r[3]};

  lsrc_div #(
    .COORD_WIDTH (W),
    .SIDE_W      (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[NST]),
    .in_ready  (div_ready),
    .in_num    (s7_num_r),
    .in_den    (s7_den_r),
    .in_side   (div_side_in),
    .out_valid (div_valid),
    .out_ready (out_rdy),
    .out_quo   (div_quo),
    .out_side  (div_side_out)
  );

  // output word register
  logic                vis_d;
  logic signed [W-1:0] base_d [4];
  logic signed [W-1:0] res_d  [4];
  logic                out_valid_r, out_visible_r;
  logic signed [W-1:0] out_c_r [4];

  assign vis_d     = div_side_out[SIDE_W-1];
  assign base_d[0] = div_side_out[4*W-1:3*W];
  assign base_d[1] = div_side_out[3*W-1:2*W];
  assign base_d[2] = div_side_out[2*W-1:W];
  assign base_d[3] = div_side_out[W-1:0];

  for (genvar l = 0; l < 4; l++) begin : g_res
    assign res_d[l] = vis_d ? (base_d[l] + $signed(div_quo[l])) : '0;
  end

  assign out_rdy = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_visible_r <= vis_d;
      out_c_r       <= res_d;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_visible         = out_visible_r;
  assign out_clipped_start_x = out_c_r[0];
  assign out_clipped_start_y = out_c_r[1];
  assign out_clipped_end_x   = out_c_r[2];
  assign out_clipped_end_y   = out_c_r[3];

`ifndef SYNTHESIS
  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  a_hidden_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_clipped_start_x == '0 && out_clipped_start_y == '0
      && out_clipped_end_x == '0 && out_clipped_end_y == '0)
    else $error("rejected word carries coordinates");

  a_start_x_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_clipped_start_x >= clip_x_min_r
      && out_clipped_start_x <= clip_x_max_r)
    else $error("clipped start x outside rectangle");

  a_end_y_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_clipped_end_y >= clip_y_min_r
      && out_clipped_end_y <= clip_y_max_r)
    else $error("clipped end y outside rectangle");
`endif

endmodule

// ----- sim/tb_line_segment_rect_clip_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_rect_clip_core
// Self-checking bench for the segment clipping core. Segments go through the
// core in phases, each under its own clip rectangle. A scoreboard computes
// every result with exact ratio arithmetic and checks the returned words in
// order. Random stalls on both sides are switched off for the last phase.
// ----------------------------------------------------------------------------
module tb_line_segment_rect_clip_core;

  localparam int CW = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    logic                 vis;
    logic signed [CW-1:0] sx, sy, ex, ey;
  } clip_word_t;

  class clip_scoreboard;
    longint     x_min, x_max, y_min, y_max;
    clip_word_t expected_q[$];
    int         errors;

    function new();
      x_min = 0; x_max = 32767; y_min = 0; y_max = 32767;
      errors = 0;
    endfunction

    function void set_edge(lsrc_pkg::cfg_reg_t idx, logic signed [CW-1:0] v);
      case (idx)
        lsrc_pkg::REG_X_MIN: x_min = v;
        lsrc_pkg::REG_X_MAX: x_max = v;
        lsrc_pkg::REG_Y_MIN: y_min = v;
        lsrc_pkg::REG_Y_MAX: y_max = v;
        default: ;
      endcase
    endfunction

    // sign of a/b - c/d with b, d > 0
    function int ratio_sign(longint a, longint b, longint c, longint d);
      longint diff;
      diff = a * d - c * b;
      return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
    endfunction

    function bit edge_pass(longint p, longint q, inout longint n1, inout longint d1,
                           inout longint n2, inout longint d2);
      if (p == 0) return q >= 0;
      if (p < 0) begin
        if (ratio_sign(-q, -p, n2, d2) > 0) return 0;
        if (ratio_sign(-q, -p, n1, d1) > 0) begin
          n1 = -q; d1 = -p;
        end
      end else begin
        if (ratio_sign(q, p, n1, d1) < 0) return 0;
        if (ratio_sign(q, p, n2, d2) < 0) begin
          n2 = q; d2 = p;
        end
      end
      return 1;
    endfunction

    // c1 + (n/d)*(c2-c1), nearest with ties upward
    function logic signed [CW-1:0] lerp_round(longint c1, longint c2, longint n, longint d);
      longint num, den, quo;
      num = 2 * n * (c2 - c1) + d;
      den = 2 * d;
      quo = num / den;
      if ((num % den != 0) && (num < 0)) quo = quo - 1;
      return CW'(c1 + quo);
    endfunction

    function void note_input(segment_t s);
      longint x1, y1, dx, dy, n1, d1, n2, d2;
      clip_word_t w;
      x1 = s.sx; y1 = s.sy;
      dx = longint'(s.ex) - x1; dy = longint'(s.ey) - y1;
      n1 = 0; d1 = 1; n2 = 1; d2 = 1;
      w = '{0, 0, 0, 0, 0};
      if (edge_pass(-dx, x1 - x_min, n1, d1, n2, d2) &&
          edge_pass(dx, x_max - x1, n1, d1, n2, d2) &&
          edge_pass(-dy, y1 - y_min, n1, d1, n2, d2) &&
          edge_pass(dy, y_max - y1, n1, d1, n2, d2)) begin
        w.vis = 1;
        w.sx = lerp_round(x1, s.ex, n1, d1);
        w.sy = lerp_round(y1, s.ey, n1, d1);
        w.ex = lerp_round(x1, s.ex, n2, d2);
        w.ey = lerp_round(y1, s.ey, n2, d2);
      end
      expected_q.insert(expected_q.size(), w);
    endfunction

    function void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(clip_word_t a);
      clip_word_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word expected none actual vis=%0b", $time, a.vis);
        return;
      end
      e = expected_q.pop_front();
      check_field("visible", e.vis, a.vis);
      check_field("clipped_start_x", e.sx, a.sx);
      check_field("clipped_start_y", e.sy, a.sy);
      check_field("clipped_end_x", e.ex, a.ex);
      check_field("clipped_end_y", e.ey, a.ey);
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  lsrc_pkg::cfg_reg_t cfg_index;
  logic signed [CW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [CW-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic out_valid, out_ready, out_visible;
  logic signed [CW-1:0] out_clipped_start_x, out_clipped_start_y;
  logic signed [CW-1:0] out_clipped_end_x, out_clipped_end_y;

  clip_scoreboard sb = new();
  bit  quiet;
  int  cycles;

  line_segment_rect_clip_core #(.COORD_WIDTH(CW)) dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_visible, out_clipped_start_x, out_clipped_start_y,
                        out_clipped_end_x, out_clipped_end_y});

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic send_segment(segment_t s);
    in_valid <= 1;
    in_start_x <= s.sx; in_start_y <= s.sy; in_end_x <= s.ex; in_end_y <= s.ey;
    do @(posedge clk); while (!in_ready);
    sb.note_input(s);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // stop input, let the pipeline empty, then rewrite the rectangle
  task automatic set_rect(logic signed [CW-1:0] xl, logic signed [CW-1:0] xh,
                          logic signed [CW-1:0] yl, logic signed [CW-1:0] yh);
    logic signed [CW-1:0] vals[4];
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    vals = '{xl, xh, yl, yh};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1;
      cfg_index <= lsrc_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_edge(lsrc_pkg::cfg_reg_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 0;
  endtask

  function automatic logic signed [CW-1:0] pick_coord(longint lo, longint hi);
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $signed(CW'($urandom));
      3: v = ($urandom_range(0, 1)) ? -32768 : 32767;
      4: v = ($urandom_range(0, 1)) ? lo : hi;
      default: begin
        v = lo - 40 + longint'($urandom_range(0, 1000000)) % (hi - lo + 81);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
      end
    endcase
    return CW'(v);
  endfunction

  task automatic random_phase(int count);
    segment_t s;
    longint lo_x, hi_x, lo_y, hi_y;
    lo_x = sb.x_min; hi_x = sb.x_max; lo_y = sb.y_min; hi_y = sb.y_max;
    if (hi_x < lo_x) hi_x = lo_x;
    if (hi_y < lo_y) hi_y = lo_y;
    for (int i = 0; i < count; i++) begin
      s.sx = pick_coord(lo_x, hi_x); s.sy = pick_coord(lo_y, hi_y);
      s.ex = pick_coord(lo_x, hi_x); s.ey = pick_coord(lo_y, hi_y);
      if ($urandom_range(0, 15) == 0) begin
        s.ex = s.sx; s.ey = s.sy;
      end
      if ($urandom_range(0, 15) == 0) s.ex = s.sx;
      if ($urandom_range(0, 15) == 0) s.ey = s.sy;
      send_segment(s);
    end
  endtask

  initial begin
    segment_t directed[$];
    rst_n = 0; quiet = 0; cycles = 0;
    cfg_valid = 0; cfg_index = lsrc_pkg::REG_X_MIN; cfg_data = 0;
    in_valid = 0; in_start_x = 0; in_start_y = 0; in_end_x = 0; in_end_y = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // reset rectangle
    directed = '{'{-32768, -32768, 32767, 32767}, '{32767, 32767, -32768, -32768},
                 '{-1, -1, -1, -1}, '{0, 0, 0, 0}, '{-5, 10, 20, 10},
                 '{32767, 0, 32767, 32767}};
    foreach (directed[i]) send_segment(directed[i]);

    set_rect(-100, 100, -50, 50);
    directed = '{'{-10, -10, 10, 10}, '{-200, 0, 200, 0}, '{0, -300, 0, 300},
                 '{-200, 60, 200, 60}, '{150, -200, 150, 200}, '{-300, -10, -150, 10},
                 '{-100, -50, 100, 50}, '{-200, -100, 0, 0}, '{100, 50, 100, 50},
                 '{101, 0, 101, 0}, '{5, 7, 5, 7}, '{-150, 50, -50, 50},
                 '{-32768, -32768, 32767, 32767}, '{7, -33, -201, 77},
                 '{-101, -51, -101, 60}, '{-150, 0, -100, 40}};
    foreach (directed[i]) send_segment(directed[i]);

    random_phase(130);
    set_rect(-32768, 32767, -32768, 32767);
    random_phase(110);
    set_rect(20, -20, -5, 5);
    random_phase(60);
    set_rect(3, 3, -7, -7);
    random_phase(80);
    set_rect(32767, 32767, -32768, -32768);
    random_phase(60);
    for (int k = 0; k < 2; k++) begin
      logic signed [CW-1:0] a, b, c, d;
      a = $urandom; b = $urandom; c = $urandom; d = $urandom;
      set_rect(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c);
      random_phase(90);
    end
    set_rect(-1000, 2500, -3000, 800);
    quiet = 1;
    random_phase(130);

    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lsrc_pkg.sv
rtl/core/lsrc_div.sv
rtl/core/line_segment_rect_clip_core.sv
sim/tb_line_segment_rect_clip_core.sv
